// ===== sv/iba_pkg.sv =====
package iba_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_USED     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_TOOLARGE = 3'd4
  } status_t;

  localparam int OP_W     = 2;
  localparam int ID_W     = 5;
  localparam int SIZE_W   = 6;
  localparam int STATUS_W = 3;
  localparam int BLK_W    = 7;
  localparam int FREE_W   = 8;

  // request handed from front to back
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  file_id;
    logic [SIZE_W-1:0] size;
  } req_t;

endpackage

// ===== sv/iba_ram.sv =====
module iba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/iba_front.sv =====
module iba_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [iba_pkg::OP_W-1:0]   in_op,
  input  logic [iba_pkg::ID_W-1:0]   in_file_id,
  input  logic [iba_pkg::SIZE_W-1:0] in_size,
  output logic                  q_valid,
  output iba_pkg::req_t         q_req,
  input  logic                  q_pop
);
  import iba_pkg::*;

  // two-entry queue between front and back
  req_t       buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) buf_r[wp_r] <= '{op: op_t'(in_op), file_id: in_file_id, size: in_size};
  end
endmodule

// ===== sv/iba_back.sv =====
module iba_back #(
  parameter int NUM_BLOCKS      = 128,
  parameter int NUM_FILES       = 32,
  parameter int MAX_FILE_BLOCKS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  iba_pkg::req_t         q_req,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [iba_pkg::STATUS_W-1:0] out_status,
  output logic [iba_pkg::BLK_W-1:0]    out_block_index,
  output logic                  out_last,
  output logic [iba_pkg::FREE_W-1:0]   out_free_count
);
  import iba_pkg::*;

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int FIW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int NW  = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_DEPTH = NUM_FILES * MAX_FILE_BLOCKS;
  localparam int IAW = $clog2(IDX_DEPTH);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_SCHK = 9'b000001000,
    S_RDA  = 9'b000010000,
    S_RDW  = 9'b000100000,
    S_DEL  = 9'b001000000,
    S_LST  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [NUM_FILES-1:0]  valid_r, valid_nxt;
  logic [NW-1:0]         sz_r [NUM_FILES];
  logic [CW-1:0]         free_r, free_nxt;
  req_t                  req_r, req_nxt;
  logic [BW-1:0]         blk_r, blk_nxt;
  logic [NW-1:0]         n_r, n_nxt, len_r, len_nxt;
  logic                  sz_we;
  // output register
  logic                  ov_r, ov_nxt;
  logic [STATUS_W-1:0]   ost_r, ost_nxt;
  logic [BLK_W-1:0]      oblk_r, oblk_nxt;
  logic                  olast_r, olast_nxt;
  logic [FREE_W-1:0]     ofree_r, ofree_nxt;

  logic                  idx_we;
  logic [IAW-1:0]        idx_waddr, idx_raddr;
  logic [BW-1:0]         idx_rdata;

  // block-used bitmap, read at blk_r
  logic                  used_we;
  logic [BW-1:0]         used_waddr;
  logic                  used_wdata;
  logic                  used_rdata;

  iba_ram #(.WIDTH(BW), .DEPTH(IDX_DEPTH)) u_idx (
    .clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(blk_r),
    .raddr(idx_raddr), .rdata(idx_rdata)
  );

  iba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_used (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .raddr(blk_r), .rdata(used_rdata)
  );

  logic [FIW-1:0] fid;
  logic           id_ok;
  logic [NW-1:0]  fsz;
  logic           out_free;

  assign fid   = FIW'(req_r.file_id);
  assign id_ok = ({1'b0, req_r.file_id} < (ID_W+1)'(NUM_FILES));
  assign fsz   = sz_r[fid];
  assign out_free = !ov_r || !out_stall;
  assign idx_waddr = IAW'(fid * MAX_FILE_BLOCKS + n_r);
  assign idx_raddr = IAW'(fid * MAX_FILE_BLOCKS + n_r);

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    free_nxt  = free_r;
    req_nxt   = req_r;
    blk_nxt   = blk_r;
    n_nxt     = n_r;
    len_nxt   = len_r;
    sz_we     = 1'b0;
    idx_we    = 1'b0;
    used_we   = 1'b0;
    used_waddr = blk_r;
    used_wdata = 1'b0;
    q_pop     = 1'b0;
    ov_nxt    = ov_r && out_stall;
    ost_nxt   = ost_r;
    oblk_nxt  = oblk_r;
    olast_nxt = olast_r;
    ofree_nxt = ofree_r;
    case (state_r)
      S_CLR: begin
        // clearing pass over the bitmap after reset
        used_we = 1'b1;
        blk_nxt = blk_r + 1'b1;
        if (blk_r == BW'(NUM_BLOCKS - 1)) begin
          blk_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          req_nxt   = q_req;
          blk_nxt   = '0;
          n_nxt     = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // classify; a single result or start of long work
        if (out_free) begin
          ost_nxt   = ST_OK;
          oblk_nxt  = '0;
          olast_nxt = 1'b1;
          ofree_nxt = FREE_W'(free_r);
          if (!id_ok || req_r.op == OP_BAD) begin
            ov_nxt = 1'b1; ost_nxt = ST_NOTFOUND; state_nxt = S_IDLE;
          end else if (req_r.op == OP_INSERT) begin
            if (valid_r[fid]) begin
              ov_nxt = 1'b1; ost_nxt = ST_USED; state_nxt = S_IDLE;
            end else if ({1'b0, req_r.size} > (SIZE_W+1)'(MAX_FILE_BLOCKS)) begin
              ov_nxt = 1'b1; ost_nxt = ST_TOOLARGE; state_nxt = S_IDLE;
            end else if (CW'(req_r.size) > free_r) begin
              ov_nxt = 1'b1; ost_nxt = ST_NOSPACE; state_nxt = S_IDLE;
            end else begin
              len_nxt = NW'(req_r.size);
              state_nxt = S_SCAN;
            end
          end else if (!valid_r[fid]) begin
            ov_nxt = 1'b1; ost_nxt = ST_NOTFOUND; state_nxt = S_IDLE;
          end else begin
            len_nxt = fsz;
            if (fsz == '0) begin
              if (req_r.op == OP_DELETE) valid_nxt[fid] = 1'b0;
              ov_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              state_nxt = S_RDA;
            end
          end
        end
      end
      S_SCAN: begin
        // bitmap read of blk_r is issued here, checked in S_SCHK
        if (n_r == len_r) begin
          sz_we = 1'b1;
          valid_nxt[fid] = 1'b1;
          free_nxt = free_r - CW'(len_r);
          ov_nxt = 1'b1; ost_nxt = ST_OK; oblk_nxt = '0; olast_nxt = 1'b1;
          ofree_nxt = FREE_W'(free_r - CW'(len_r));
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        // lowest free block first
        if (!used_rdata) begin
          used_we    = 1'b1;
          used_wdata = 1'b1;
          idx_we     = 1'b1;
          n_nxt      = n_r + 1'b1;
        end
        blk_nxt   = blk_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_RDA: state_nxt = S_RDW;
      S_RDW: state_nxt = (req_r.op == OP_DELETE) ? S_DEL : S_LST;
      S_DEL: begin
        // index entries of a live file always name used blocks
        used_we    = 1'b1;
        used_waddr = idx_rdata;
        free_nxt   = free_r + 1'b1;
        if (n_r + 1'b1 == len_r) begin
          valid_nxt[fid] = 1'b0;
          ov_nxt = 1'b1; ost_nxt = ST_OK; oblk_nxt = '0; olast_nxt = 1'b1;
          ofree_nxt = FREE_W'(free_nxt);
          state_nxt = S_IDLE;
        end else begin
          n_nxt = n_r + 1'b1;
          state_nxt = S_RDA;
        end
      end
      S_LST: begin
        if (out_free) begin
          ov_nxt = 1'b1; ost_nxt = ST_OK;
          oblk_nxt  = BLK_W'(idx_rdata);
          olast_nxt = (n_r + 1'b1 == len_r);
          ofree_nxt = FREE_W'(free_r);
          n_nxt = n_r + 1'b1;
          state_nxt = (n_r + 1'b1 == len_r) ? S_IDLE : S_RDA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      blk_r   <= '0;
      valid_r <= '0;
      free_r  <= CW'(NUM_BLOCKS);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      blk_r   <= blk_nxt;
      valid_r <= valid_nxt;
      free_r  <= free_nxt;
      ov_r    <= ov_nxt;
    end
    req_r   <= req_nxt;
    n_r     <= n_nxt;
    len_r   <= len_nxt;
    ost_r   <= ost_nxt;
    oblk_r  <= oblk_nxt;
    olast_r <= olast_nxt;
    ofree_r <= ofree_nxt;
    if (sz_we) sz_r[fid] <= len_r;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_block_index = oblk_r;
  assign out_last        = olast_r;
  assign out_free_count  = ofree_r;
endmodule

// ===== sv/indexed_block_allocator_unit.sv =====
// flow: a request is taken in S_IDLE and classified in S_OUT once the output register is
// free; a one-result request has its result registered there. Insert then alternates
// S_SCAN and S_SCHK per block examined, delete steps S_RDA, S_RDW, S_DEL per block, and
// list S_RDA, S_RDW, S_LST per result. The back end serves one request at a time; a
// two-deep request queue takes input while it has room and raises in_stall when full.
// reset: synchronous active low; all blocks free, no files, free count NUM_BLOCKS; a
// bitmap clearing pass runs before the first request is served.
module indexed_block_allocator_unit #(
  parameter int NUM_BLOCKS      = 128,
  parameter int NUM_FILES       = 32,
  parameter int MAX_FILE_BLOCKS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [iba_pkg::OP_W-1:0]   in_op,
  input  logic [iba_pkg::ID_W-1:0]   in_file_id,
  input  logic [iba_pkg::SIZE_W-1:0] in_size,
  output logic out_valid,
  input  logic out_stall,
  output logic [iba_pkg::STATUS_W-1:0] out_status,
  output logic [iba_pkg::BLK_W-1:0]    out_block_index,
  output logic out_last,
  output logic [iba_pkg::FREE_W-1:0]   out_free_count
);
  import iba_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;

  iba_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_file_id, .in_size,
    .q_valid, .q_req, .q_pop
  );

  iba_back #(
    .NUM_BLOCKS(NUM_BLOCKS), .NUM_FILES(NUM_FILES), .MAX_FILE_BLOCKS(MAX_FILE_BLOCKS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop, .out_valid, .out_stall,
    .out_status, .out_block_index, .out_last, .out_free_count
  );
endmodule
